// ----- rtl/ts_adaptation_field_parser_top_defines.svh -----
// assertion macros for the adaptation field parser
`ifndef TS_ADAPTATION_FIELD_PARSER_TOP_DEFINES_SVH
`define TS_ADAPTATION_FIELD_PARSER_TOP_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define TSAFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define TSAFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tsafp_pkg.sv -----
`timescale 1ns / 1ps

package tsafp_pkg;

    // parser sections in stream order
    typedef enum logic [3:0] {
        PH_LEN      = 4'd0,
        PH_FLAGS    = 4'd1,
        PH_PCR      = 4'd2,
        PH_OPCR     = 4'd3,
        PH_SPLICE   = 4'd4,
        PH_PRIVLEN  = 4'd5,
        PH_PRIVDATA = 4'd6,
        PH_EXTLEN   = 4'd7,
        PH_EXTFLAGS = 4'd8,
        PH_LTW      = 4'd9,
        PH_RATE     = 4'd10,
        PH_SEAM     = 4'd11,
        PH_DONE     = 4'd12
    } phase_t;

    localparam int PhaseLast = 11;

    // field ids of the result stream
    localparam logic [3:0] FID_LENGTH      = 4'd0;
    localparam logic [3:0] FID_FLAGS       = 4'd1;
    localparam logic [3:0] FID_PCR_BASE    = 4'd2;
    localparam logic [3:0] FID_PCR_EXT     = 4'd3;
    localparam logic [3:0] FID_OPCR_BASE   = 4'd4;
    localparam logic [3:0] FID_OPCR_EXT    = 4'd5;
    localparam logic [3:0] FID_SPLICE      = 4'd6;
    localparam logic [3:0] FID_PRIV_LEN    = 4'd7;
    localparam logic [3:0] FID_PRIV_BYTE   = 4'd8;
    localparam logic [3:0] FID_EXT_LEN     = 4'd9;
    localparam logic [3:0] FID_EXT_FLAGS   = 4'd10;
    localparam logic [3:0] FID_LTW         = 4'd11;
    localparam logic [3:0] FID_RATE        = 4'd12;
    localparam logic [3:0] FID_SPLICE_TYPE = 4'd13;
    localparam logic [3:0] FID_DTS         = 4'd14;

    // bytes gathered for multi-byte fields
    localparam logic [2:0] GATHER_CLOCK_REF = 3'd6;
    localparam logic [2:0] GATHER_LTW       = 3'd2;
    localparam logic [2:0] GATHER_RATE      = 3'd3;
    localparam logic [2:0] GATHER_SEAM      = 3'd5;

    // result queue
    localparam int FifoAw    = 3;
    localparam int FifoDepth = 1 << FifoAw;

    typedef struct packed {
        logic [3:0]  id;
        logic [32:0] value;
        logic [5:0]  aux;
        logic        last;
    } result_t;

    // first enabled section after cur, or PH_DONE
    function automatic phase_t next_phase(phase_t cur, logic [7:0] mf, logic [2:0] ef,
                                          logic [7:0] pr);
        logic [PhaseLast:0] en;
        phase_t             np;
        en              = '0;
        en[PH_PCR]      = mf[4];
        en[PH_OPCR]     = mf[3];
        en[PH_SPLICE]   = mf[2];
        en[PH_PRIVLEN]  = mf[1];
        en[PH_PRIVDATA] = mf[1] && (pr != 8'd0);
        en[PH_EXTLEN]   = mf[0];
        en[PH_EXTFLAGS] = mf[0];
        en[PH_LTW]      = mf[0] && ef[2];
        en[PH_RATE]     = mf[0] && ef[1];
        en[PH_SEAM]     = mf[0] && ef[0];
        np = PH_DONE;
        for (int q = PhaseLast; q >= 1; q--)
        begin
            if ((q > int'(cur)) && en[q])
            begin
                np = phase_t'(4'(q));
            end
        end
        return np;
    endfunction

endpackage

// ----- rtl/ts_adaptation_field_parser_top.sv -----
`timescale 1ns / 1ps
// channel  | handshake           | payload
// input    | in_valid / in_ready | data_byte, start_req, af_present
// output   | out_valid/out_ready | field_id, field_value, aux_bits, last
//
// one byte accepted per cycle while in_ready is high; a byte is decoded in the cycle after it is taken
// its results (none, one or two) enter an 8-entry queue; one result leaves per cycle while out_ready is high
// in_ready drops when the queue, after room for two results of any staged byte, could not hold two more
// a stalled output side fills the queue and then stalls the input side
// rst_n clears parser state, the input-stage valid flag, the queue pointers and the fill count
`include "ts_adaptation_field_parser_top_defines.svh"

module ts_adaptation_field_parser_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_req,
    input  logic        af_present,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  field_id,
    output logic [32:0] field_value,
    output logic [5:0]  aux_bits,
    output logic        last
);

    localparam int CntW = tsafp_pkg::FifoAw + 1;

    // input stage
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_start_reg;
    logic       s1_present_reg;

    // parser state
    logic              active_reg, active_next;
    tsafp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]        main_flags_reg, main_flags_next;
    logic [2:0]        ext_flags_reg, ext_flags_next;
    logic [47:0]       gather_shift_reg, gather_shift_next;
    logic [2:0]        gather_count_reg, gather_count_next;
    logic [7:0]        priv_rem_reg, priv_rem_next;

    // result queue
    tsafp_pkg::result_t           fifo_mem [tsafp_pkg::FifoDepth];
    logic [tsafp_pkg::FifoAw-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]              count_reg;

    logic               in_acc, pop;
    logic [7:0]         mf_upd, pr_upd;
    logic [2:0]         ef_upd;
    tsafp_pkg::phase_t  adv_phase;
    logic               adv_fin;
    logic [47:0]        gs_shift;
    logic [2:0]         gc_inc;
    logic [2:0]         gather_need;
    logic               gather_done;
    logic               do_advance;
    logic               fin;
    tsafp_pkg::result_t r0, r1;
    logic [1:0]         n_push;

    assign in_acc   = in_valid && in_ready;
    assign pop      = out_valid && out_ready;
    assign in_ready = ({1'b0, count_reg} + {{(CntW-1){1'b0}}, s1_valid_reg, 1'b0})
                      <= (CntW+1)'(tsafp_pkg::FifoDepth - 2);

    // input stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_byte_reg    <= data_byte;
            s1_start_reg   <= start_req;
            s1_present_reg <= af_present;
        end
    end

    // flags and counts as they stand after this byte
    assign mf_upd = (phase_reg == tsafp_pkg::PH_FLAGS) ? s1_byte_reg : main_flags_reg;
    assign ef_upd = (phase_reg == tsafp_pkg::PH_EXTFLAGS) ? s1_byte_reg[7:5] : ext_flags_reg;
    assign pr_upd = (phase_reg == tsafp_pkg::PH_PRIVLEN)  ? s1_byte_reg :
                    (phase_reg == tsafp_pkg::PH_PRIVDATA) ? (priv_rem_reg - 8'd1) :
                    priv_rem_reg;

    assign adv_phase = tsafp_pkg::next_phase(phase_reg, mf_upd, ef_upd, pr_upd);
    assign adv_fin   = (adv_phase == tsafp_pkg::PH_DONE);

    // byte gathering for multi-byte fields
    assign gs_shift = {gather_shift_reg[39:0], s1_byte_reg};
    assign gc_inc   = gather_count_reg + 3'd1;

    always_comb
    begin
        unique case (phase_reg)
            tsafp_pkg::PH_PCR,
            tsafp_pkg::PH_OPCR: gather_need = tsafp_pkg::GATHER_CLOCK_REF;
            tsafp_pkg::PH_LTW:  gather_need = tsafp_pkg::GATHER_LTW;
            tsafp_pkg::PH_RATE: gather_need = tsafp_pkg::GATHER_RATE;
            tsafp_pkg::PH_SEAM: gather_need = tsafp_pkg::GATHER_SEAM;
            default:            gather_need = 3'd0;
        endcase
    end

    assign gather_done = (gather_need != 3'd0) && (gc_inc >= gather_need);

    // whether this byte closes the current section
    always_comb
    begin
        unique case (phase_reg)
            tsafp_pkg::PH_FLAGS,
            tsafp_pkg::PH_SPLICE,
            tsafp_pkg::PH_PRIVLEN,
            tsafp_pkg::PH_EXTLEN,
            tsafp_pkg::PH_EXTFLAGS: do_advance = 1'b1;
            tsafp_pkg::PH_PRIVDATA: do_advance = (pr_upd == 8'd0);
            tsafp_pkg::PH_PCR,
            tsafp_pkg::PH_OPCR,
            tsafp_pkg::PH_LTW,
            tsafp_pkg::PH_RATE,
            tsafp_pkg::PH_SEAM:     do_advance = gather_done;
            default:                do_advance = 1'b0;
        endcase
    end

    assign fin = do_advance && adv_fin;

    // next parser state
    always_comb
    begin
        active_next       = active_reg;
        phase_next        = phase_reg;
        main_flags_next   = main_flags_reg;
        ext_flags_next    = ext_flags_reg;
        gather_shift_next = gather_shift_reg;
        gather_count_next = gather_count_reg;
        priv_rem_next     = priv_rem_reg;
        if (s1_valid_reg)
        begin
            if (s1_start_reg)
            begin
                active_next       = 1'b0;
                phase_next        = tsafp_pkg::PH_LEN;
                main_flags_next   = 8'd0;
                ext_flags_next    = 3'd0;
                gather_shift_next = 48'd0;
                gather_count_next = 3'd0;
                priv_rem_next     = 8'd0;
                if (s1_present_reg && (s1_byte_reg != 8'd0))
                begin
                    active_next = 1'b1;
                    phase_next  = tsafp_pkg::PH_FLAGS;
                end
            end
            else if (active_reg)
            begin
                main_flags_next = mf_upd;
                ext_flags_next  = ef_upd;
                priv_rem_next   = pr_upd;
                unique case (phase_reg)
                    tsafp_pkg::PH_PCR,
                    tsafp_pkg::PH_OPCR,
                    tsafp_pkg::PH_LTW,
                    tsafp_pkg::PH_RATE,
                    tsafp_pkg::PH_SEAM:
                    begin
                        gather_shift_next = gs_shift;
                        gather_count_next = gc_inc;
                    end
                    tsafp_pkg::PH_FLAGS,
                    tsafp_pkg::PH_SPLICE,
                    tsafp_pkg::PH_PRIVLEN,
                    tsafp_pkg::PH_PRIVDATA,
                    tsafp_pkg::PH_EXTLEN,
                    tsafp_pkg::PH_EXTFLAGS:
                    begin
                    end
                    default:
                    begin
                        active_next = 1'b0;
                        phase_next  = tsafp_pkg::PH_LEN;
                    end
                endcase
                if (do_advance)
                begin
                    gather_shift_next = 48'd0;
                    gather_count_next = 3'd0;
                    if (adv_fin)
                    begin
                        active_next = 1'b0;
                        phase_next  = tsafp_pkg::PH_LEN;
                    end
                    else
                    begin
                        phase_next = adv_phase;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg       <= 1'b0;
            phase_reg        <= tsafp_pkg::PH_LEN;
            main_flags_reg   <= 8'd0;
            ext_flags_reg    <= 3'd0;
            gather_shift_reg <= 48'd0;
            gather_count_reg <= 3'd0;
            priv_rem_reg     <= 8'd0;
        end
        else
        begin
            active_reg       <= active_next;
            phase_reg        <= phase_next;
            main_flags_reg   <= main_flags_next;
            ext_flags_reg    <= ext_flags_next;
            gather_shift_reg <= gather_shift_next;
            gather_count_reg <= gather_count_next;
            priv_rem_reg     <= priv_rem_next;
        end
    end

    // results of this byte
    always_comb
    begin
        r0     = '0;
        r1     = '0;
        n_push = 2'd0;
        if (s1_valid_reg)
        begin
            if (s1_start_reg)
            begin
                n_push = 2'd1;
                r0.id  = tsafp_pkg::FID_LENGTH;
                if (s1_present_reg && (s1_byte_reg != 8'd0))
                begin
                    r0.value = {25'd0, s1_byte_reg};
                end
                else
                begin
                    r0.last = 1'b1;
                end
            end
            else if (active_reg)
            begin
                unique case (phase_reg)
                    tsafp_pkg::PH_FLAGS:
                    begin
                        n_push   = 2'd1;
                        r0.id    = tsafp_pkg::FID_FLAGS;
                        r0.value = {25'd0, s1_byte_reg};
                        r0.last  = fin;
                    end
                    tsafp_pkg::PH_PCR,
                    tsafp_pkg::PH_OPCR:
                    begin
                        if (gather_done)
                        begin
                            n_push   = 2'd2;
                            r0.id    = (phase_reg == tsafp_pkg::PH_PCR) ?
                                       tsafp_pkg::FID_PCR_BASE : tsafp_pkg::FID_OPCR_BASE;
                            r0.value = gs_shift[47:15];
                            r1.id    = (phase_reg == tsafp_pkg::PH_PCR) ?
                                       tsafp_pkg::FID_PCR_EXT : tsafp_pkg::FID_OPCR_EXT;
                            r1.value = {24'd0, gs_shift[8:0]};
                            r1.aux   = gs_shift[14:9];
                            r1.last  = fin;
                        end
                    end
                    tsafp_pkg::PH_SPLICE:
                    begin
                        n_push   = 2'd1;
                        r0.id    = tsafp_pkg::FID_SPLICE;
                        r0.value = {25'd0, s1_byte_reg};
                        r0.last  = fin;
                    end
                    tsafp_pkg::PH_PRIVLEN:
                    begin
                        n_push   = 2'd1;
                        r0.id    = tsafp_pkg::FID_PRIV_LEN;
                        r0.value = {25'd0, s1_byte_reg};
                        r0.last  = fin;
                    end
                    tsafp_pkg::PH_PRIVDATA:
                    begin
                        n_push   = 2'd1;
                        r0.id    = tsafp_pkg::FID_PRIV_BYTE;
                        r0.value = {25'd0, s1_byte_reg};
                        r0.last  = fin;
                    end
                    tsafp_pkg::PH_EXTLEN:
                    begin
                        n_push   = 2'd1;
                        r0.id    = tsafp_pkg::FID_EXT_LEN;
                        r0.value = {25'd0, s1_byte_reg};
                        r0.last  = fin;
                    end
                    tsafp_pkg::PH_EXTFLAGS:
                    begin
                        n_push   = 2'd1;
                        r0.id    = tsafp_pkg::FID_EXT_FLAGS;
                        r0.value = {30'd0, s1_byte_reg[7:5]};
                        r0.aux   = {1'b0, s1_byte_reg[4:0]};
                        r0.last  = fin;
                    end
                    tsafp_pkg::PH_LTW:
                    begin
                        if (gather_done)
                        begin
                            n_push   = 2'd1;
                            r0.id    = tsafp_pkg::FID_LTW;
                            r0.value = {18'd0, gs_shift[14:0]};
                            r0.aux   = {5'd0, gs_shift[15]};
                            r0.last  = fin;
                        end
                    end
                    tsafp_pkg::PH_RATE:
                    begin
                        if (gather_done)
                        begin
                            n_push   = 2'd1;
                            r0.id    = tsafp_pkg::FID_RATE;
                            r0.value = {11'd0, gs_shift[21:0]};
                            r0.aux   = {4'd0, gs_shift[23:22]};
                            r0.last  = fin;
                        end
                    end
                    tsafp_pkg::PH_SEAM:
                    begin
                        if (gather_done)
                        begin
                            n_push   = 2'd2;
                            r0.id    = tsafp_pkg::FID_SPLICE_TYPE;
                            r0.value = {29'd0, gs_shift[39:36]};
                            r1.id    = tsafp_pkg::FID_DTS;
                            r1.value = {gs_shift[35:33], gs_shift[31:17], gs_shift[15:1]};
                            r1.aux   = {3'd0, gs_shift[32], gs_shift[16], gs_shift[0]};
                            r1.last  = fin;
                        end
                    end
                    default:
                    begin
                        n_push = 2'd0;
                    end
                endcase
            end
        end
    end

    // result queue write side
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= r0;
        end
        if (n_push == 2'd2)
        begin
            fifo_mem[wr_ptr_reg + tsafp_pkg::FifoAw'(1)] <= r1;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + tsafp_pkg::FifoAw'(n_push);
            rd_ptr_reg <= rd_ptr_reg + tsafp_pkg::FifoAw'(pop);
            count_reg  <= count_reg + CntW'(n_push) - CntW'(pop);
        end
    end

    // head of queue drives the output transaction
    assign out_valid   = (count_reg != '0);
    assign field_id    = fifo_mem[rd_ptr_reg].id;
    assign field_value = fifo_mem[rd_ptr_reg].value;
    assign aux_bits    = fifo_mem[rd_ptr_reg].aux;
    assign last        = fifo_mem[rd_ptr_reg].last;

    // checks
    `TSAFP_ASSERT_NOW(a_room_for_byte, s1_valid_reg,
        count_reg <= CntW'(tsafp_pkg::FifoDepth - 2), "queue too full for a decoded byte")
    `TSAFP_ASSERT_NOW(a_pair_source, n_push == 2'd2,
        !s1_start_reg && (phase_reg == tsafp_pkg::PH_PCR || phase_reg == tsafp_pkg::PH_OPCR ||
        phase_reg == tsafp_pkg::PH_SEAM), "two results from a single-result section")
    `TSAFP_ASSERT_NEXT(a_last_stops, s1_valid_reg && !s1_start_reg && (r0.last || r1.last),
        !active_reg, "parser still active after the last result")
    `TSAFP_ASSERT_NOW(a_active_phase, active_reg,
        phase_reg != tsafp_pkg::PH_LEN && phase_reg != tsafp_pkg::PH_DONE,
        "active parser in an idle section")

endmodule
